// ===== design/risc_instruction_execute_core_assert.svh =====
// assertion macros for the execute core
`ifndef RISC_INSTRUCTION_EXECUTE_CORE_ASSERT_SVH
`define RISC_INSTRUCTION_EXECUTE_CORE_ASSERT_SVH
`define RIEC_ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define RIEC_ASSERT_ONEHOT(label, clk, rst, sig) \
  label: assert property (@(posedge clk) disable iff (rst) $onehot(sig)) \
    else $error("state not one-hot");
`endif

// ===== design/riec_pkg.sv =====
// types and constants shared by the execute core modules
package riec_pkg;
  localparam int PC_W = 22;
  localparam int ADDR_W = 10;
  localparam int REGISTER_COUNT = 32;
  localparam int DATA_WORDS = 1024;
  localparam int CACHE_LINES = 64;
  localparam int WORDS_PER_LINE = 4;
  localparam logic [4:0] OP_STOP = 5'd0, OP_ADD = 5'd1, OP_SUB = 5'd2, OP_MULT = 5'd3,
    OP_DIV = 5'd4, OP_AND = 5'd5, OP_OR = 5'd6, OP_XOR = 5'd7, OP_SHL = 5'd8,
    OP_SHR = 5'd9, OP_SLT = 5'd10, OP_SLE = 5'd11, OP_SEQ = 5'd12, OP_LOAD = 5'd13,
    OP_STORE = 5'd14, OP_JMP = 5'd15, OP_BRAZ = 5'd16, OP_BRANZ = 5'd17,
    OP_SCALL = 5'd18;

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b0000000001,
    ST_CLEAR   = 10'b0000000010,
    ST_READ    = 10'b0000000100,
    ST_EXEC    = 10'b0000001000,
    ST_DIV     = 10'b0000010000,
    ST_TAG     = 10'b0000100000,
    ST_FILL    = 10'b0001000000,
    ST_LREAD   = 10'b0010000000,
    ST_WB      = 10'b0100000000,
    ST_OUT     = 10'b1000000000
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic latch;
    logic read;
    logic exec;
    logic div_start;
    logic div_step;
    logic tag_read;
    logic fill_step;
    logic line_read;
    logic writeback;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic running;
    logic is_div;
    logic div_done;
    logic is_load;
    logic hit;
    logic fill_done;
  } status_t;
endpackage

// ===== design/riec_control.sv =====
// sequencer for the execute core
module riec_control import riec_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
    case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (!status.running) state_next = ST_WB;
        else if (status.is_div) begin
          cmd.div_start = 1'b1;
          state_next = ST_DIV;
        end else if (status.is_load) begin
          cmd.tag_read = 1'b1;
          state_next = ST_TAG;
        end else begin
          cmd.exec = 1'b1;
          state_next = ST_WB;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) state_next = ST_WB;
      end
      ST_TAG: begin
        if (status.hit) state_next = ST_LREAD;
        else state_next = ST_FILL;
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (status.fill_done) state_next = ST_LREAD;
      end
      ST_LREAD: begin
        cmd.line_read = 1'b1;
        state_next = ST_WB;
      end
      ST_WB: begin
        cmd.writeback = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `include "risc_instruction_execute_core_assert.svh"
  `RIEC_ASSERT_ONEHOT(a_state_onehot, clk, rst, state)
  `RIEC_ASSERT_IMPL(a_no_accept_busy, clk, rst, (state == ST_OUT) |-> !in_ready)
  `RIEC_ASSERT_IMPL(a_wb_then_out, clk, rst, (state == ST_WB) |=> (state == ST_OUT))
endmodule

// ===== design/riec_datapath.sv =====
// registers, alu, divider, data memory and read cache of the execute core
module riec_datapath import riec_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic        [31:0] instr_word,
  input  logic signed [31:0] input_value,
  output logic        [21:0] next_pc,
  output logic               halted,
  output logic               input_taken,
  output logic               display_valid,
  output logic signed [31:0] display_value,
  output logic               cache_access,
  output logic               cache_hit,
  output logic               divide_by_zero,
  output logic        [31:0] op_count
);
  logic [31:0] regs [REGISTER_COUNT];
  logic [31:0] dmem [DATA_WORDS];
  logic [31:0] lwords [CACHE_LINES * WORDS_PER_LINE];
  logic [CACHE_LINES-1:0] lvalid;
  logic [1:0]  ltag [CACHE_LINES];

  logic [31:0] iw, inval, a, b, rdv, res;
  logic [PC_W-1:0] pc, npc;
  logic        run, wr_en, dz, taken, disp, acc, hit;
  logic [31:0] cnt, dval;
  logic [4:0]  wr_idx;
  logic [10:0] clr;
  logic [1:0]  fcnt;
  logic [1:0]  fidx;
  logic [31:0] mem_q;
  logic [1:0]  tag_q;
  logic        valid_q;
  logic [5:0]  dcnt;
  logic [31:0] quo, rem, dvsr;
  logic        dneg;
  logic [31:0] sra;

  logic [4:0] op;
  assign op = iw[31:27];
  logic [ADDR_W-1:0] addr;
  assign addr = ADDR_W'(a + b);
  logic [5:0] set;
  assign set = addr[7:2];

  // refill reads one word ahead of the word being written
  assign fidx = cmd.fill_step ? fcnt + 2'd1 : fcnt;
  assign sra = $signed(a) >>> b[4:0];

  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      dmem[clr[9:0]] <= '0;
      lwords[clr[7:0]] <= '0;
    end else if (cmd.exec && run && op == OP_STORE) dmem[addr] <= rdv;
    else if (cmd.fill_step) lwords[{set, fcnt}] <= mem_q;
    if (cmd.tag_read || cmd.fill_step) mem_q <= dmem[{addr[9:2], fidx}];
    if (cmd.line_read) res <= lwords[{set, addr[1:0]}];
    else if (cmd.exec) begin
      case (op)
        OP_ADD: res <= a + b;
        OP_SUB: res <= a - b;
        OP_MULT: res <= a * b;
        OP_AND: res <= a & b;
        OP_OR: res <= a | b;
        OP_XOR: res <= a ^ b;
        OP_SHL: res <= (b >= 32) ? '0 : a << b[4:0];
        OP_SHR: res <= (b >= 32) ? {32{a[31]}} : sra;
        OP_SLT: res <= {31'd0, $signed(a) < $signed(b)};
        OP_SLE: res <= {31'd0, $signed(a) <= $signed(b)};
        OP_SEQ: res <= {31'd0, a == b};
        OP_JMP: res <= {10'd0, 22'(pc + 22'd1)};
        OP_SCALL: res <= inval;
        default: res <= '0;
      endcase
    end else if (cmd.div_step && dcnt == 6'd32) begin
      if (dvsr == 0) res <= '1;
      else res <= dneg ? 32'(-quo) : quo;
    end
  end

  logic [31:0] rem_sh;
  assign rem_sh = {rem[30:0], quo[31]};
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo <= a[31] ? 32'(-a) : a;
      dvsr <= b[31] ? 32'(-b) : b;
      dneg <= a[31] ^ b[31];
      rem <= '0;
      dcnt <= '0;
    end else if (cmd.div_step && dcnt != 6'd32) begin
      dcnt <= dcnt + 6'd1;
      if ({rem, quo[31]} >= {1'b0, dvsr}) begin
        rem <= 32'({rem, quo[31]} - {1'b0, dvsr});
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      iw <= instr_word;
      inval <= input_value;
    end
    if (cmd.read) begin
      a <= regs[iw[26:22]];
      b <= iw[21] ? {16'd0, iw[20:5]} : regs[iw[9:5]];
      rdv <= regs[iw[4:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
      fcnt <= '0;
      lvalid <= '0;
      pc <= '0;
      run <= 1'b1;
      cnt <= '0;
      for (int i = 0; i < REGISTER_COUNT; i++) regs[i] <= '0;
      {taken, disp, acc, hit, dz, dval} <= '0;
    end else begin
      if (cmd.clear_step) clr <= clr + 11'd1;
      if (cmd.latch) fcnt <= '0;
      if (cmd.tag_read) begin
        tag_q <= ltag[set];
        valid_q <= lvalid[set];
      end
      if (cmd.fill_step) begin
        fcnt <= fcnt + 2'd1;
        if (fcnt == 2'd3) begin
          lvalid[set] <= 1'b1;
          ltag[set] <= addr[9:8];
        end
      end
      if (cmd.latch) {taken, disp, acc, hit, dz, dval} <= '0;
      if (cmd.writeback && run) begin
        if (wr_en) regs[wr_idx] <= res;
        if (op <= OP_SCALL) begin
          pc <= npc;
          cnt <= cnt + ((op == OP_MULT || op == OP_DIV || op == OP_JMP ||
                        op == OP_BRAZ || op == OP_BRANZ) ? 32'd2 : 32'd1);
        end
        if (op == OP_STOP) run <= 1'b0;
        acc <= (op == OP_LOAD);
        hit <= (op == OP_LOAD) && valid_q && tag_q == addr[9:8];
        dz <= (op == OP_DIV) && b == 0;
        taken <= (op == OP_SCALL) && iw[26:0] == 0;
        disp <= (op == OP_SCALL) && iw[26:0] == 1;
        dval <= (op == OP_SCALL && iw[26:0] == 1) ? regs[1] : '0;
      end
    end
  end

  always_comb begin
    wr_en = 1'b0;
    wr_idx = iw[4:0];
    npc = 22'(pc + 22'd1);
    case (op)
      OP_ADD, OP_SUB, OP_MULT, OP_DIV, OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SHR,
      OP_SLT, OP_SLE, OP_SEQ, OP_LOAD, OP_JMP: wr_en = 1'b1;
      OP_SCALL: begin
        wr_en = (iw[26:0] == 0);
        wr_idx = 5'd1;
      end
      default: wr_en = 1'b0;
    endcase
    if (op == OP_JMP) npc = iw[26] ? {1'b0, iw[25:5]} : regs[iw[9:5]][21:0];
    if ((op == OP_BRAZ && a == 0) || (op == OP_BRANZ && a != 0)) npc = iw[21:0];
  end

  always_comb begin
    status.clear_done = (clr == 11'd1023);
    status.running = run;
    status.is_div = (op == OP_DIV);
    status.div_done = (dcnt == 6'd32);
    status.is_load = (op == OP_LOAD);
    status.hit = valid_q && tag_q == addr[9:8];
    status.fill_done = (fcnt == 2'd3);
  end

  assign next_pc = pc;
  assign halted = !run;
  assign input_taken = taken;
  assign display_valid = disp;
  assign display_value = dval;
  assign cache_access = acc;
  assign cache_hit = hit;
  assign divide_by_zero = dz;
  assign op_count = cnt;
endmodule

// ===== design/risc_instruction_execute_core.sv =====
// top level of the execute core
// channel | direction | handshake
// in      | input     | in_valid / in_ready, instr_word, input_value
// out     | output    | out_valid / out_ready, next_pc .. op_count
// an item goes read, exec, writeback; a load adds tag check, miss refill
// after reset a clear of data memory runs before the first beat
// a waiting result holds the core until taken
module risc_instruction_execute_core import riec_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic        [31:0] instr_word,
  input  logic signed [31:0] input_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [21:0] next_pc,
  output logic               halted,
  output logic               input_taken,
  output logic               display_valid,
  output logic signed [31:0] display_value,
  output logic               cache_access,
  output logic               cache_hit,
  output logic               divide_by_zero,
  output logic        [31:0] op_count
);
  cmd_t cmd;
  status_t status;

  riec_control u_ctrl (.clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .status, .cmd);
  riec_datapath u_dp (.clk, .rst, .cmd, .status, .instr_word, .input_value,
    .next_pc, .halted, .input_taken, .display_valid, .display_value,
    .cache_access, .cache_hit, .divide_by_zero, .op_count);
endmodule

// ===== tb/risc_instruction_execute_core_test.sv =====
// self-checking testbench for the instruction execute core
`timescale 1ns / 100ps
module risc_instruction_execute_core_test;
  import riec_pkg::*;

  typedef struct {
    logic [21:0] pc;
    logic        halt;
    logic        taken;
    logic        disp;
    logic [31:0] dval;
    logic        acc;
    logic        hit;
    logic        dz;
    logic [31:0] cnt;
  } outcome_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [31:0] instr_word;
  logic signed [31:0] input_value;
  logic [21:0] next_pc;
  logic halted, input_taken, display_valid, cache_access, cache_hit, divide_by_zero;
  logic signed [31:0] display_value;
  logic [31:0] op_count;

  risc_instruction_execute_core DUT (.*);

  logic [31:0] regs [32];
  logic [31:0] dmem [1024];
  logic        line_ok [64];
  logic [1:0]  line_tg [64];
  logic [31:0] line_dat [256];
  logic [21:0] pc_model;
  logic        running;
  logic [31:0] weight_sum;

  outcome_t pending_q[$];
  int errors = 0;
  int send_idle = 0, recv_idle = 0;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("** risc_instruction_execute_core: FAILED **");
    $finish;
  end

  function automatic logic [31:0] enc(logic [4:0] op, logic [4:0] ra, logic imm,
                                      logic [15:0] b, logic [4:0] rd);
    return {op, ra, imm, b, rd};
  endfunction

  task automatic execute_model(logic [31:0] w, logic [31:0] inval);
    outcome_t o;
    logic [4:0] op, ra, rd;
    logic [31:0] a, b, addr, tgt;
    logic [21:0] npc;
    logic [1:0] tg;
    logic [5:0] ln;
    logic [31:0] wt;
    o = '{default: 0};
    if (running) begin
      op = w[31:27];
      ra = w[26:22];
      rd = w[4:0];
      a = regs[ra];
      b = w[21] ? {16'd0, w[20:5]} : regs[w[9:5]];
      npc = pc_model + 22'd1;
      wt = 1;
      case (op)
        OP_STOP: running = 0;
        OP_ADD: regs[rd] = a + b;
        OP_SUB: regs[rd] = a - b;
        OP_MULT: begin
          regs[rd] = a * b;
          wt = 2;
        end
        OP_DIV: begin
          wt = 2;
          if (b == 0) begin
            o.dz = 1;
            regs[rd] = 32'hFFFFFFFF;
          end else if (a == 32'h80000000 && b == 32'hFFFFFFFF) regs[rd] = 32'h80000000;
          else regs[rd] = $signed(a) / $signed(b);
        end
        OP_AND: regs[rd] = a & b;
        OP_OR: regs[rd] = a | b;
        OP_XOR: regs[rd] = a ^ b;
        OP_SHL: regs[rd] = (b >= 32) ? 32'd0 : a << b[4:0];
        OP_SHR: begin
          if (b >= 32) regs[rd] = {32{a[31]}};
          else regs[rd] = $signed(a) >>> b[4:0];
        end
        OP_SLT: regs[rd] = ($signed(a) < $signed(b)) ? 1 : 0;
        OP_SLE: regs[rd] = ($signed(a) <= $signed(b)) ? 1 : 0;
        OP_SEQ: regs[rd] = (a == b) ? 1 : 0;
        OP_LOAD: begin
          addr = (a + b) & 32'h3FF;
          tg = addr[9:8];
          ln = addr[7:2];
          o.acc = 1;
          if (line_ok[ln] && line_tg[ln] == tg) o.hit = 1;
          else begin
            for (int k = 0; k < 4; k++) line_dat[ln * 4 + k] = dmem[{tg, ln, 2'(k)}];
            line_ok[ln] = 1;
            line_tg[ln] = tg;
          end
          regs[rd] = line_dat[ln * 4 + addr[1:0]];
        end
        OP_STORE: dmem[(a + b) & 32'h3FF] = regs[rd];
        OP_JMP: begin
          wt = 2;
          tgt = {11'd0, w[25:5]};
          if (!w[26]) tgt = regs[w[9:5]] & 32'h3FFFFF;
          regs[rd] = {10'd0, npc};
          npc = tgt[21:0];
        end
        OP_BRAZ, OP_BRANZ: begin
          wt = 2;
          if ((op == OP_BRAZ) == (regs[ra] == 0)) npc = w[21:0];
        end
        OP_SCALL: begin
          if (w[26:0] == 0) begin
            regs[1] = inval;
            o.taken = 1;
          end else if (w[26:0] == 1) begin
            o.disp = 1;
            o.dval = regs[1];
          end
        end
        default: begin
          wt = 0;
          npc = pc_model;
        end
      endcase
      weight_sum += wt;
      pc_model = npc;
    end
    o.pc = pc_model;
    o.halt = !running;
    o.cnt = weight_sum;
    pending_q.push_back(o);
  endtask

  task automatic send_beat(logic [31:0] w, logic [31:0] v);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    instr_word <= w;
    input_value <= v;
    do @(posedge clk); while (!in_ready);
    execute_model(w, v);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  initial begin
    out_ready = 0;
    @(negedge clk);
    forever begin
      out_ready <= ($urandom_range(99) >= recv_idle);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    outcome_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        report("unexpected result beat, next_pc", {10'd0, next_pc}, 32'd0);
      end else begin
        e = pending_q.pop_front();
        if (next_pc !== e.pc) report("next_pc", next_pc, e.pc);
        if (halted !== e.halt) report("halted", halted, e.halt);
        if (input_taken !== e.taken) report("input_taken", input_taken, e.taken);
        if (display_valid !== e.disp) report("display_valid", display_valid, e.disp);
        if (display_value !== e.dval) report("display_value", display_value, e.dval);
        if (cache_access !== e.acc) report("cache_access", cache_access, e.acc);
        if (cache_hit !== e.hit) report("cache_hit", cache_hit, e.hit);
        if (divide_by_zero !== e.dz) report("divide_by_zero", divide_by_zero, e.dz);
        if (op_count !== e.cnt) report("op_count", op_count, e.cnt);
      end
    end
  end

  task automatic test_directed();
    send_beat(enc(OP_ADD, 0, 1, 16'hFFFF, 5), 0);
    send_beat(enc(OP_SUB, 0, 1, 16'd1, 3), 0);
    send_beat(enc(OP_ADD, 0, 1, 16'd1, 2), 0);
    send_beat(enc(OP_SHL, 2, 1, 16'd31, 2), 0);
    send_beat(enc(OP_DIV, 2, 0, 16'd3, 4), 0);
    send_beat(enc(OP_DIV, 5, 0, 16'd9, 6), 0);
    send_beat(enc(OP_MULT, 3, 0, 16'd5, 7), 0);
    send_beat(enc(OP_DIV, 7, 1, 16'd3, 8), 0);
    send_beat(enc(OP_SHL, 5, 1, 16'd32, 9), 0);
    send_beat(enc(OP_SHR, 2, 1, 16'd40, 10), 0);
    send_beat(enc(OP_SHR, 2, 1, 16'd4, 10), 0);
    send_beat(enc(OP_SLT, 2, 0, 16'd5, 11), 0);
    send_beat(enc(OP_SLE, 5, 1, 16'hFFFF, 11), 0);
    send_beat(enc(OP_SEQ, 3, 0, 16'd3, 12), 0);
    send_beat(enc(OP_STORE, 5, 1, 16'd1, 3), 0);
    send_beat(enc(OP_LOAD, 3, 1, 16'd1025, 13), 0);
    send_beat(enc(OP_STORE, 5, 1, 16'd2, 5), 0);
    send_beat(enc(OP_LOAD, 5, 1, 16'd2, 14), 0);
    send_beat({OP_SCALL, 27'd0}, 32'h80000000);
    send_beat({OP_SCALL, 27'd1}, 0);
    send_beat({OP_SCALL, 27'd5}, 0);
    send_beat({OP_JMP, 1'b1, 21'h1FFFFF, 5'd15}, 0);
    send_beat({OP_JMP, 1'b0, 16'd0, 5'd3, 5'd16}, 0);
    send_beat({OP_BRAZ, 5'd0, 22'h3FFFFF}, 0);
    send_beat({OP_BRANZ, 5'd3, 22'h000010}, 0);
    send_beat({5'd25, 27'h5A5A5A5}, 0);
  endtask

  task automatic test_random(int n);
    logic [31:0] w;
    logic [4:0] op;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        w = $urandom;
        if (w[31:27] == OP_STOP) w[31:27] = OP_ADD;
      end else begin
        op = 5'($urandom_range(18, 1));
        if ($urandom_range(3) == 0) op = $urandom_range(1) ? OP_LOAD : OP_STORE;
        w = enc(op, 5'($urandom), 1'($urandom),
                $urandom_range(1) ? 16'($urandom_range(63)) : 16'($urandom), 5'($urandom));
        if (op == OP_SCALL) w[26:0] = 27'($urandom_range(2));
      end
      send_beat(w, $urandom);
    end
  endtask

  task automatic test_halt();
    send_beat({OP_STOP, 27'h7FFFFFF}, 0);
    for (int i = 0; i < 6; i++) send_beat($urandom, $urandom);
  endtask

  initial begin
    foreach (regs[i]) regs[i] = 0;
    foreach (dmem[i]) dmem[i] = 0;
    foreach (line_ok[i]) begin
      line_ok[i] = 0;
      line_tg[i] = 0;
    end
    foreach (line_dat[i]) line_dat[i] = 0;
    pc_model = 0;
    running = 1;
    weight_sum = 0;
    rst = 1;
    in_valid = 0;
    instr_word = 0;
    input_value = 0;
    repeat (7) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    send_idle = 7;
    recv_idle = 73;
    test_directed();
    test_random(530);
    drain();
    send_idle = 73;
    recv_idle = 7;
    test_random(530);
    drain();
    send_idle = 0;
    recv_idle = 0;
    test_random(530);
    test_halt();
    drain();
    if (errors == 0 && pending_q.size() == 0)
      $display("** risc_instruction_execute_core: PASSED **");
    else
      $display("** risc_instruction_execute_core: FAILED **");
    $finish;
  end
endmodule
